// File: design/des_rf_pkg.sv
// Tables, types and helper functions shared by the DES round function modules
package des_rf_pkg;

    localparam int HALF_BITS = 32;
    localparam int EXP_BITS  = 48;
    localparam int N_SBOX    = 8;
    localparam int GRP_BITS  = 6;
    localparam int SOUT_BITS = 4;

    typedef logic [HALF_BITS-1:0] t_half;
    typedef logic [EXP_BITS-1:0]  t_exp;
    typedef logic [SOUT_BITS-1:0] t_nib;
    typedef logic [GRP_BITS-1:0]  t_grp;

    // expansion table, DES bit numbers with bit one the msb
    localparam int E_TAB [EXP_BITS] = '{
        32,  1,  2,  3,  4,  5,  4,  5,  6,  7,  8,  9,
         8,  9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
        16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
        24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32,  1
    };

    // permutation table applied to the s-box word
    localparam int P_TAB [HALF_BITS] = '{
        16,  7, 20, 21, 29, 12, 28, 17,  1, 15, 23, 26,  5, 18, 31, 10,
         2,  8, 24, 14, 32, 27,  3,  9, 19, 13, 30,  6, 22, 11,  4, 25
    };

    // substitution boxes, indexed by box, row, column
    localparam t_nib S_TAB [N_SBOX][4][16] = '{
        '{'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
            4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7},
          '{4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
            4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8},
          '{4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
            4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0},
          '{4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
            4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13}},
        '{'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
            4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10},
          '{4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
            4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5},
          '{4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
            4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15},
          '{4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
            4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9}},
        '{'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
            4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8},
          '{4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
            4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
          '{4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
            4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7},
          '{4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
            4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12}},
        '{'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
            4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15},
          '{4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
            4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9},
          '{4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
            4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4},
          '{4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
            4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14}},
        '{'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
            4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9},
          '{4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
            4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6},
          '{4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
            4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14},
          '{4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
            4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3}},
        '{'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
            4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11},
          '{4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
            4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8},
          '{4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
            4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6},
          '{4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
            4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13}},
        '{'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
            4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1},
          '{4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
            4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6},
          '{4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
            4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2},
          '{4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
            4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12}},
        '{'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
            4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7},
          '{4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
            4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2},
          '{4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
            4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8},
          '{4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
            4'd15, 4'd12, 4'd11, 4'd5, 4'd0, 4'd3, 4'd9, 4'd6}}
    };

    // expansion of the right half to 48 bits, pure wiring
    function automatic t_exp f_expand(input t_half r);
        t_exp x;
        for (int i = 0; i < EXP_BITS; i++) begin
            x[EXP_BITS-1-i] = r[HALF_BITS-E_TAB[i]];
        end
        return x;
    endfunction

    // lookup in one s-box: row from the outer bits, column from the inner four
    function automatic t_nib f_sbox(input int box, input t_grp g);
        return S_TAB[box][{g[5], g[0]}][g[4:1]];
    endfunction

    // permutation of the s-box word, pure wiring
    function automatic t_half f_permute(input t_half s);
        t_half p;
        for (int i = 0; i < HALF_BITS; i++) begin
            p[HALF_BITS-1-i] = s[HALF_BITS-P_TAB[i]];
        end
        return p;
    endfunction

endpackage

// File: design/des_rf_sbox_p.sv
// Substitution layer of the round function: eight s-boxes followed by the P permutation
module des_rf_sbox_p
    import des_rf_pkg::*;
(
    input  t_exp  i_x,
    output t_half o_f
);

    t_half w_s;

    // eight independent 6-to-4 lookups, box 1 on the most significant group
    always_comb begin
        for (int i = 0; i < N_SBOX; i++) begin
            w_s[HALF_BITS-1-SOUT_BITS*i -: SOUT_BITS] =
                f_sbox(i, i_x[EXP_BITS-1-GRP_BITS*i -: GRP_BITS]);
        end
    end

    // final bit permutation
    assign o_f = f_permute(w_s);

endmodule

// File: design/des_round_function.sv
// DES round function f(R, K): input register, expansion, key mix, s-boxes, P, result register
// Each accepted item passes the input register and then the result register before its result is offered.
// Throughput: one item per cycle, with no gaps, as long as the output side does not stall.
// A stall on the output holds the result register, then the input register, then the input.
// Reset (synchronous, active low) clears only the two valid flags; data registers keep their value.
// The block keeps no other state.
module des_round_function
    import des_rf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_half i_right_half,
    input  t_exp  i_round_key,
    output logic  o_valid,
    input  logic  i_stall,
    output t_half o_f_out
);

    logic  r_in_valid;
    t_half r_right;
    t_exp  r_key;
    logic  r_out_valid;
    t_half r_f;

    logic  w_advance;
    logic  w_load;
    t_exp  w_x;
    t_half w_f;

    // pipeline control: result register frees up when empty or being taken
    assign w_advance = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !w_advance;
    assign w_load    = i_valid && !o_stall;

    // expansion and key mix on the registered item
    assign w_x = f_expand(r_right) ^ r_key;

    des_rf_sbox_p u_sbox_p (
        .i_x (w_x),
        .o_f (w_f)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
        end
        if (w_load) begin
            r_right <= i_right_half;
            r_key   <= i_round_key;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
        if (w_advance && r_in_valid) begin
            r_f <= w_f;
        end
    end

    assign o_valid = r_out_valid;
    assign o_f_out = r_f;

`ifndef NO_ASSERTIONS
    // an item in the input register moves to the result register with its value
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_advance) |=> (r_out_valid && r_f == $past(w_f)))
        else $error("item not moved to result register");

    // a held item in the input register is not lost or overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_right) && $stable(r_key)))
        else $error("held item lost");

    // the input is stalled only when both registers are full and the output stalls
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without cause");

    // an accepted item reaches the input register
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_in_valid && r_right == $past(i_right_half)))
        else $error("accepted item not captured");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the DES round function f(R, K) with its own table-driven predictor
module tb;
    import des_rf_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 8;

    // s-box rows, four per box, sixteen nibbles each with column 0 in the top nibble
    localparam logic [63:0] SBOX_ROW [32] = '{
        64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538, 64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D,
        64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5, 64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9,
        64'hA09E63F51DC7B428, 64'hD709346A285ECBF1, 64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C,
        64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9, 64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E,
        64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986, 64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453,
        64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38, 64'h9EF528C3704A1DB6, 64'h432C95FABE17608D,
        64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86, 64'h14BDC37EAF680592, 64'h6BD814A7950FE23C,
        64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92, 64'h7B419CE206ADF358, 64'h21E74A8DFCB50396
    };

    // source bit of each output bit of the final permutation, bit one is the msb
    localparam int PERM_SRC [32] = '{
        16,  7, 20, 21, 29, 12, 28, 17,  1, 15, 23, 26,  5, 18, 31, 10,
         2,  8, 24, 14, 32, 27,  3,  9, 19, 13, 30,  6, 22, 11,  4, 25
    };

    typedef struct {
        t_half right_half;
        t_exp  round_key;
        t_half f_out;
    } t_f_expect;

    logic  i_clk        = 1'b0;
    logic  i_rst_n      = 1'b0;
    logic  i_valid      = 1'b0;
    logic  i_stall      = 1'b0;
    t_half i_right_half = '0;
    t_exp  i_round_key  = '0;
    logic  o_stall;
    logic  o_valid;
    t_half o_f_out;

    t_f_expect f_expected_q [$];
    t_f_expect f_head;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int hold_off_left     = 0;
    int mismatch_count    = 0;
    int cycle_count       = 0;

    des_round_function u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_right_half (i_right_half),
        .i_round_key  (i_round_key),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_f_out      (o_f_out)
    );

    // f(R, K): expand, mix in the key, substitute, permute
    function automatic t_half des_round_f(input t_half r, input t_exp k);
        t_exp       x;
        t_half      s;
        t_half      p;
        logic [5:0] g;
        logic [63:0] row;
        int         n;
        int         col;
        // each 6-bit group takes DES bits 4g .. 4g+5 of the half, wrapping at both ends
        for (int grp = 0; grp < 8; grp++) begin
            for (int j = 0; j < 6; j++) begin
                n = 4 * grp + j;
                if (n == 0) begin
                    n = 32;
                end else if (n == 33) begin
                    n = 1;
                end
                x[47 - 6 * grp - j] = r[32 - n];
            end
        end
        x = x ^ k;
        // row from the outer bits of the group, column from the inner four
        for (int b = 0; b < 8; b++) begin
            g   = x[47 - 6 * b -: 6];
            row = SBOX_ROW[4 * b + 2 * g[5] + g[0]];
            col = g[4:1];
            s[31 - 4 * b -: 4] = row[63 - 4 * col -: 4];
        end
        for (int i = 0; i < 32; i++) begin
            p[31 - i] = s[32 - PERM_SRC[i]];
        end
        return p;
    endfunction

    function automatic t_exp random_key();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // clock
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, f_expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side stall: long hold-off when requested, otherwise random
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            i_stall       <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (f_expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got f_out %h",
                         $time, o_f_out);
                mismatch_count <= mismatch_count + 1;
            end else begin
                f_head = f_expected_q.pop_front();
                if (o_f_out !== f_head.f_out) begin
                    $display("%0t: f_out mismatch for R %h K %h: expected %h, actual %h",
                             $time, f_head.right_half, f_head.round_key,
                             f_head.f_out, o_f_out);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    // offer one item after a random gap and record its result once accepted
    task automatic send_item(input t_half r, input t_exp k);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_right_half <= r;
        i_round_key  <= k;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        f_expected_q.push_back('{r, k, des_round_f(r, k)});
    endtask

    // random content, now and then an all-zero or all-one field
    task automatic send_random_item();
        t_half r;
        t_exp  k;
        r = $urandom;
        k = random_key();
        case ($urandom_range(0, 15))
            0: begin
                r = '0;
            end
            1: begin
                r = '1;
            end
            2: begin
                k = '0;
            end
            3: begin
                k = '1;
            end
            default: begin
            end
        endcase
        send_item(r, k);
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (f_expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // field extremes, expansion wrap bits, every s-box row, and a published round value
    task automatic test_directed();
        send_item('0, '0);
        send_item('1, '1);
        send_item('1, '0);
        send_item('0, '1);
        send_item(32'h55555555, 48'hAAAAAAAAAAAA);
        send_item(32'hAAAAAAAA, 48'h555555555555);
        send_item(32'h80000000, 48'h000000000000);
        send_item(32'h00000001, 48'h000000000000);
        send_item(32'h80000001, 48'h800000000001);
        send_item(32'h00000000, 48'h800000000000);
        send_item(32'h00000000, 48'h000000000001);
        send_item(32'h00000000, 48'h041041041041);
        send_item(32'h00000000, 48'h820820820820);
        send_item(32'h00000000, 48'h861861861861);
        send_item(32'h00000000, 48'h79E79E79E79E);
        send_item(32'hF0AAF0AA, 48'h1B02EFFC7072);
        send_item(32'h0F0F0F0F, 48'hFFFF0000FFFF);
    endtask

    task automatic test_random(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            send_random_item();
        end
    endtask

    // sender stops until the block has returned everything, then carries on
    task automatic test_sender_pause();
        test_random(30);
        wait_results_drained();
        test_random(30);
    endtask

    // long result stall while items keep coming, so the input side must stall too
    task automatic test_backpressure();
        hold_off_left = HOLD_OFF_CYCLES;
        test_random(40);
    endtask

    initial begin
        // reset
        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles less, receiver more
        sender_idle_pct   = 22;
        receiver_idle_pct = 66;
        test_directed();
        test_random(400);
        test_sender_pause();

        // the other way round
        sender_idle_pct   = 66;
        receiver_idle_pct = 22;
        test_random(400);

        // no idling on either side
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random(300);
        test_backpressure();

        // drain and let any stray result show up
        i_valid <= 1'b0;
        while (f_expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/des_rf_pkg.sv
design/des_rf_sbox_p.sv
design/des_round_function.sv
tb/tb.sv
